### design/sel_pkg.sv
// Package for the shared/exclusive lock manager.
// Sizes, payload structs and sequencer state codes; no dependencies.
package sel_pkg;

  localparam int NUM_KEYS    = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_TXNS    = 256;
  localparam int KEY_BITS    = 32;

  localparam int SLOT_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TIDX_W = $clog2(NUM_TXNS);
  localparam int ENT_AW = SLOT_W + IDX_W;
  localparam int ENT_W  = 9;
  localparam int WC_W   = 16;

  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_READ   = 2'd1;
  localparam logic [1:0] FN_REL    = 2'd2;
  localparam logic [1:0] FN_STATUS = 2'd3;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SHR  = 2'd1;
  localparam logic [1:0] MODE_EXC  = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_TABLE = 2'd1;
  localparam logic [1:0] ERR_QUEUE = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] lock_key;
    logic [7:0]  txn_id;
  } in_item_t;

  typedef struct packed {
    logic       granted;
    logic [1:0] lock_mode;
    logic [7:0] result_txn;
    logic       result_txn_valid;
    logic [1:0] error_code;
    logic       last_item;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LOOK   = 13'b0000000000010,
    S_SCN_RD = 13'b0000000000100,
    S_SCN_DT = 13'b0000000001000,
    S_WC_RD  = 13'b0000000010000,
    S_WC_DT  = 13'b0000000100000,
    S_FND_DT = 13'b0000001000000,
    S_SH_RD  = 13'b0000010000000,
    S_SH_DT  = 13'b0000100000000,
    S_RWC_DT = 13'b0001000000000,
    S_REL_END= 13'b0010000000000,
    S_STA_DT = 13'b0100000000000,
    S_FLUSH  = 13'b1000000000000
  } state_t;

endpackage

### design/sel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sel_front.sv
// Front end: two-entry request queue between the input channel and the sequencer.
// Depends on sel_pkg.
module sel_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sel_pkg::in_item_t in_data,
  output sel_pkg::hs_t      req_hs_o,
  input  logic              req_pop,
  output sel_pkg::in_item_t req_data
);

  sel_pkg::in_item_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = req_pop && (cnt_r != 2'd0);
  assign req_hs_o = '{valid: (cnt_r != 2'd0), ready: req_pop};
  assign req_data = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_r] <= in_data;
    end
  end

endmodule

### design/sel_back.sv
// Back end: key table, queue memory, wait counts and the request sequencer.
// Depends on sel_pkg and sel_ram.
module sel_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sel_pkg::hs_t       req_hs_i,
  output logic               req_pop,
  input  sel_pkg::in_item_t  req_data,
  output logic               emit_valid,
  output sel_pkg::out_item_t emit_item,
  input  logic               emit_ready
);

  localparam int SW = sel_pkg::SLOT_W;
  localparam int IW = sel_pkg::IDX_W;
  localparam int LW = sel_pkg::LEN_W;
  localparam int TW = sel_pkg::TIDX_W;
  localparam int KB = sel_pkg::KEY_BITS;

  sel_pkg::state_t state_r, state_nxt;

  logic [KB-1:0]  tag_r  [sel_pkg::NUM_KEYS];
  logic           used_r [sel_pkg::NUM_KEYS];
  logic [LW-1:0]  qlen_r [sel_pkg::NUM_KEYS];
  logic           wcv_r  [sel_pkg::NUM_TXNS];

  logic [1:0]     func_r;
  logic [KB-1:0]  key_r;
  logic [7:0]     txn_r;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [LW-1:0]  i_r, i_nxt;
  logic [LW-1:0]  waits_r, waits_nxt;
  logic           rexc_r, rexc_nxt;
  logic [7:0]     ent_r, ent_nxt;
  logic           pend_r, pend_nxt;
  sel_pkg::out_item_t pitem_r, pitem_nxt;

  logic              hit, fre;
  logic [SW-1:0]     hit_s, fre_s;
  logic              e_we;
  logic [sel_pkg::ENT_AW-1:0] e_wa;
  logic [sel_pkg::ENT_W-1:0]  e_wd, e_rd;
  logic              w_we;
  logic [TW-1:0]     w_ra, w_wa;
  logic [sel_pkg::WC_W-1:0] w_wd, w_rd, wcur;
  logic [sel_pkg::WC_W:0]   wsum;
  logic              tab_wr, tab_rel;
  sel_pkg::out_item_t nitem;
  logic              stall;

  sel_ram #(.WIDTH(sel_pkg::ENT_W), .DEPTH(sel_pkg::NUM_KEYS * sel_pkg::QUEUE_DEPTH)) u_ent (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd),
    .raddr({slot_r, i_r[IW-1:0]}), .rdata(e_rd)
  );

  sel_ram #(.WIDTH(sel_pkg::WC_W), .DEPTH(sel_pkg::NUM_TXNS)) u_wc (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd),
    .raddr(w_ra), .rdata(w_rd)
  );

  always_comb begin
    hit   = 1'b0;
    hit_s = '0;
    fre   = 1'b0;
    fre_s = '0;
    for (int s = sel_pkg::NUM_KEYS - 1; s >= 0; s--) begin
      if (used_r[s] && tag_r[s] == key_r) begin
        hit   = 1'b1;
        hit_s = SW'(s);
      end
      if (!used_r[s]) begin
        fre   = 1'b1;
        fre_s = SW'(s);
      end
    end
  end

  assign w_ra = (state_r == sel_pkg::S_RWC_DT || state_r == sel_pkg::S_SH_DT) ?
                ent_nxt[TW-1:0] : txn_r[TW-1:0];
  assign wcur = wcv_r[w_ra] ? w_rd : '0;
  assign wsum = {1'b0, wcur} + (sel_pkg::WC_W + 1)'(waits_r);
  assign req_pop = (state_r == sel_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    len_nxt    = len_r;
    i_nxt      = i_r;
    waits_nxt  = waits_r;
    rexc_nxt   = rexc_r;
    ent_nxt    = ent_r;
    pend_nxt   = pend_r;
    pitem_nxt  = pitem_r;
    e_we       = 1'b0;
    e_wa       = {slot_r, len_r[IW-1:0]};
    e_wd       = {txn_r, func_r == sel_pkg::FN_WRITE};
    w_we       = 1'b0;
    w_wa       = txn_r[TW-1:0];
    w_wd       = wsum[sel_pkg::WC_W] ? '1 : wsum[sel_pkg::WC_W-1:0];
    tab_wr     = 1'b0;
    tab_rel    = 1'b0;
    emit_valid = 1'b0;
    emit_item  = pitem_r;
    stall      = 1'b0;
    nitem      = '{default: '0};
    case (state_r)
      sel_pkg::S_IDLE: begin
        if (req_hs_i.valid) begin
          state_nxt = sel_pkg::S_LOOK;
        end
      end
      sel_pkg::S_LOOK: begin
        pend_nxt  = 1'b1;
        pitem_nxt = '{default: '0};
        i_nxt     = '0;
        waits_nxt = '0;
        slot_nxt  = hit ? hit_s : fre_s;
        len_nxt   = hit ? qlen_r[hit_s] : '0;
        state_nxt = sel_pkg::S_FLUSH;
        case (func_r)
          sel_pkg::FN_WRITE, sel_pkg::FN_READ: begin
            if (!hit && !fre) begin
              pitem_nxt.error_code = sel_pkg::ERR_TABLE;
            end else if (hit && qlen_r[hit_s] >= LW'(sel_pkg::QUEUE_DEPTH)) begin
              pitem_nxt.error_code = sel_pkg::ERR_QUEUE;
            end else if (func_r == sel_pkg::FN_WRITE) begin
              waits_nxt = hit ? qlen_r[hit_s] : '0;
              state_nxt = sel_pkg::S_WC_RD;
            end else begin
              state_nxt = (hit) ? sel_pkg::S_SCN_RD : sel_pkg::S_WC_RD;
            end
          end
          sel_pkg::FN_REL: begin
            if (hit) begin
              state_nxt = sel_pkg::S_SCN_RD;
            end
          end
          default: begin
            if (hit) begin
              pend_nxt  = 1'b0;
              state_nxt = sel_pkg::S_SCN_RD;
            end
          end
        endcase
      end
      sel_pkg::S_SCN_RD: begin
        case (func_r)
          sel_pkg::FN_REL:    state_nxt = sel_pkg::S_FND_DT;
          sel_pkg::FN_STATUS: state_nxt = sel_pkg::S_STA_DT;
          default:            state_nxt = sel_pkg::S_SCN_DT;
        endcase
      end
      sel_pkg::S_SCN_DT: begin
        waits_nxt = waits_r + LW'(e_rd[0]);
        i_nxt     = i_r + 1'b1;
        state_nxt = (i_r + 1'b1 == len_r) ? sel_pkg::S_WC_RD : sel_pkg::S_SCN_RD;
      end
      sel_pkg::S_WC_RD: begin
        state_nxt = sel_pkg::S_WC_DT;
      end
      sel_pkg::S_WC_DT: begin
        e_we   = 1'b1;
        w_we   = 1'b1;
        tab_wr = 1'b1;
        pitem_nxt.granted = (waits_r == '0);
        state_nxt = sel_pkg::S_FLUSH;
      end
      sel_pkg::S_FND_DT: begin
        i_nxt = i_r + 1'b1;
        if (e_rd[8:1] == txn_r) begin
          rexc_nxt  = e_rd[0];
          pend_nxt  = 1'b0;
          state_nxt = (i_r + 1'b1 == len_r) ? sel_pkg::S_REL_END : sel_pkg::S_SH_RD;
        end else begin
          state_nxt = (i_r + 1'b1 == len_r) ? sel_pkg::S_FLUSH : sel_pkg::S_SCN_RD;
        end
      end
      sel_pkg::S_SH_RD: begin
        state_nxt = sel_pkg::S_SH_DT;
      end
      sel_pkg::S_SH_DT: begin
        e_we    = 1'b1;
        e_wa    = {slot_r, IW'(i_r - 1'b1)};
        e_wd    = e_rd;
        ent_nxt = e_rd[8:1];
        if (rexc_r || e_rd[0]) begin
          state_nxt = sel_pkg::S_RWC_DT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = (i_r + 1'b1 == len_r) ? sel_pkg::S_REL_END : sel_pkg::S_SH_RD;
        end
      end
      sel_pkg::S_RWC_DT: begin
        nitem.result_txn       = ent_r;
        nitem.result_txn_valid = 1'b1;
        if (wcur == 16'd1 && pend_r) begin
          stall      = !emit_ready;
          emit_valid = emit_ready;
        end
        if (!stall) begin
          if (wcur != '0) begin
            w_we = 1'b1;
            w_wa = ent_r[TW-1:0];
            w_wd = wcur - 1'b1;
          end
          if (wcur == 16'd1) begin
            pend_nxt  = 1'b1;
            pitem_nxt = nitem;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = (i_r + 1'b1 == len_r) ? sel_pkg::S_REL_END : sel_pkg::S_SH_RD;
        end
      end
      sel_pkg::S_REL_END: begin
        tab_rel = 1'b1;
        if (!pend_r) begin
          pend_nxt  = 1'b1;
          pitem_nxt = '{default: '0};
        end
        state_nxt = sel_pkg::S_FLUSH;
      end
      sel_pkg::S_STA_DT: begin
        nitem.result_txn       = e_rd[8:1];
        nitem.result_txn_valid = 1'b1;
        nitem.lock_mode        = e_rd[0] ? sel_pkg::MODE_EXC : sel_pkg::MODE_SHR;
        if (e_rd[0] && i_r != '0) begin
          state_nxt = sel_pkg::S_FLUSH;
        end else begin
          if (pend_r) begin
            stall      = !emit_ready;
            emit_valid = emit_ready;
          end
          if (!stall) begin
            pend_nxt  = 1'b1;
            pitem_nxt = nitem;
            i_nxt     = i_r + 1'b1;
            state_nxt = (e_rd[0] || i_r + 1'b1 == len_r) ? sel_pkg::S_FLUSH :
                        sel_pkg::S_SCN_RD;
          end
        end
      end
      sel_pkg::S_FLUSH: begin
        emit_item.last_item = 1'b1;
        if (emit_ready) begin
          emit_valid = 1'b1;
          pend_nxt   = 1'b0;
          state_nxt  = sel_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sel_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sel_pkg::S_IDLE;
      pend_r  <= 1'b0;
      for (int s = 0; s < sel_pkg::NUM_KEYS; s++) begin
        used_r[s] <= 1'b0;
        qlen_r[s] <= '0;
      end
      for (int t = 0; t < sel_pkg::NUM_TXNS; t++) begin
        wcv_r[t] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (w_we) begin
        wcv_r[w_wa] <= 1'b1;
      end
      if (tab_wr) begin
        used_r[slot_r] <= 1'b1;
        qlen_r[slot_r] <= len_r + 1'b1;
      end
      if (tab_rel) begin
        qlen_r[slot_r] <= len_r - 1'b1;
        if (len_r == LW'(1)) begin
          used_r[slot_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sel_pkg::S_IDLE && req_hs_i.valid) begin
      func_r <= req_data.func;
      key_r  <= req_data.lock_key[KB-1:0];
      txn_r  <= req_data.txn_id;
    end
    if (tab_wr) begin
      tag_r[slot_r] <= key_r;
    end
    slot_r  <= slot_nxt;
    len_r   <= len_nxt;
    i_r     <= i_nxt;
    waits_r <= waits_nxt;
    rexc_r  <= rexc_nxt;
    ent_r   <= ent_nxt;
    pitem_r <= pitem_nxt;
  end

endmodule

### design/shared_exclusive_lock_manager_core.sv
// Shared/exclusive lock manager: request queue, sequencer and result register.
// The sequencer reads the key's queue entries one at a time; a lock request then reads and
// writes its wait count, and a release shifts the entries behind its own entry down a place.
// The sequencer serves one transaction at a time.
// Results leave through a one-deep output register. Reset (rst_n low, synchronous)
// empties the key table and clears all wait counts at once. Depends on sel_pkg, sel_front, sel_back.
module shared_exclusive_lock_manager_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sel_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sel_pkg::out_item_t out_data
);

  sel_pkg::hs_t       req_hs;
  logic               req_pop;
  sel_pkg::in_item_t  req_data;
  logic               emit_valid;
  logic               emit_ready;
  sel_pkg::out_item_t emit_item;
  logic               out_valid_r;
  sel_pkg::out_item_t out_data_r;

  sel_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .req_hs_o(req_hs), .req_pop(req_pop), .req_data(req_data)
  );

  sel_back u_back (
    .clk(clk), .rst_n(rst_n), .req_hs_i(req_hs), .req_pop(req_pop),
    .req_data(req_data), .emit_valid(emit_valid), .emit_item(emit_item),
    .emit_ready(emit_ready)
  );

  assign emit_ready = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_data_r <= emit_item;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit_valid |-> emit_ready) else $error("result produced with no room");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != sel_pkg::ERR_OK |-> out_data.last_item)
    else $error("refusal not last");

  a_rst_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid) else $error("output valid after reset");

endmodule
